// ===== src/fwp_pkg.sv =====
package fwp_pkg;

  // Input commands
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_READ_DATA = 1'b1;

  // Result kinds
  localparam logic KIND_READ_REQ = 1'b0;
  localparam logic KIND_DONE     = 1'b1;

  // Configuration register indexes
  localparam int  CFG_ADDR_W    = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROOT_BASE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DIRECT_MAP = 1'd1;

  // Address layout
  localparam int VA_W      = 48;
  localparam int PAGE_BITS = 12;
  localparam int IDX_BITS  = 9;
  localparam int PTE_SHIFT = 3;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic        command;
    logic [63:0] virtual_address;
    logic [63:0] read_data;
  } fwp_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] out_address;
    logic        passed_through;
  } fwp_out_t;

  // One queued result: the back adds the two operands
  typedef struct packed {
    logic        result_kind;
    logic        passed_through;
    logic [63:0] opnd_a;
    logic [63:0] opnd_b;
  } fwp_job_t;

endpackage

// ===== src/fwp_front.sv =====
module fwp_front #(
  parameter int LEVELS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  fwp_pkg::fwp_in_t                in_data,
  output logic                            in_stall,
  input  logic                            cfg_we,
  input  logic [fwp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [63:0]                     cfg_wdata,
  input  logic                            q_full,
  output logic                            q_push,
  output fwp_pkg::fwp_job_t               q_job
);

  localparam int LVL_W = $clog2(LEVELS);

  logic [63:0]              root_base_r;
  logic [63:0]              direct_map_r;
  logic                     busy_r, busy_nxt;
  logic [LVL_W-1:0]         level_r, level_nxt;
  logic [fwp_pkg::VA_W-1:0] saved_r, saved_nxt;

  logic                     in_accept;
  logic                     high_set;
  logic                     last_level;
  logic [63:0]              frame;
  logic [8:0]               root_idx;
  logic [8:0]               next_idx;

  // Table index of one level: bits above the 48-bit address read as zero
  function automatic logic [8:0] level_index(input logic [fwp_pkg::VA_W-1:0] addr,
                                             input logic [LVL_W-1:0] lvl);
    logic [fwp_pkg::VA_W-1:0] tmp;
    logic [8:0]               idx;
    idx = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lvl == LVL_W'(l)) begin
        tmp = addr >> (fwp_pkg::PAGE_BITS + fwp_pkg::IDX_BITS * (LEVELS - 1 - l));
        idx = tmp[8:0];
      end
    end
    return idx;
  endfunction

  assign in_stall   = q_full;
  assign in_accept  = in_valid && !in_stall;
  assign high_set   = |in_data.virtual_address[63:fwp_pkg::VA_W];
  assign last_level = (level_r == LVL_W'(LEVELS - 1));
  assign frame      = {in_data.read_data[63:fwp_pkg::PAGE_BITS], {fwp_pkg::PAGE_BITS{1'b0}}};
  assign root_idx   = level_index(in_data.virtual_address[fwp_pkg::VA_W-1:0], '0);
  assign next_idx   = level_index(saved_r, level_r + LVL_W'(1));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_base_r  <= '0;
      direct_map_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        fwp_pkg::REG_ROOT_BASE:  root_base_r  <= cfg_wdata;
        fwp_pkg::REG_DIRECT_MAP: direct_map_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify the beat and build the job for the back
  always_comb begin
    busy_nxt  = busy_r;
    level_nxt = level_r;
    saved_nxt = saved_r;
    q_push    = 1'b0;
    q_job     = '0;
    if (in_accept) begin
      if (in_data.command == fwp_pkg::CMD_TRANSLATE) begin
        if (!busy_r) begin
          q_push = 1'b1;
          if (high_set) begin
            q_job.result_kind    = fwp_pkg::KIND_DONE;
            q_job.passed_through = 1'b1;
            q_job.opnd_a         = in_data.virtual_address;
          end else begin
            q_job.result_kind = fwp_pkg::KIND_READ_REQ;
            q_job.opnd_a      = root_base_r;
            q_job.opnd_b      = {52'd0, root_idx, {fwp_pkg::PTE_SHIFT{1'b0}}};
            busy_nxt          = 1'b1;
            level_nxt         = '0;
            saved_nxt         = in_data.virtual_address[fwp_pkg::VA_W-1:0];
          end
        end
      end else if (busy_r) begin
        q_push = 1'b1;
        if (last_level) begin
          // final entry: frame plus page offset, moved into the direct map
          q_job.result_kind = fwp_pkg::KIND_DONE;
          q_job.opnd_a      = frame | {52'd0, saved_r[fwp_pkg::PAGE_BITS-1:0]};
          q_job.opnd_b      = direct_map_r;
          busy_nxt          = 1'b0;
          level_nxt         = '0;
        end else begin
          q_job.result_kind = fwp_pkg::KIND_READ_REQ;
          q_job.opnd_a      = frame;
          q_job.opnd_b      = {52'd0, next_idx, {fwp_pkg::PTE_SHIFT{1'b0}}};
          level_nxt         = level_r + LVL_W'(1);
        end
      end
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      level_r <= '0;
      saved_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      level_r <= level_nxt;
      saved_r <= saved_nxt;
    end
  end

`ifndef SYNTH
  a_idle_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> level_r == '0)
    else $error("walk level nonzero while idle");

  a_translate_busy_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.command == fwp_pkg::CMD_TRANSLATE && busy_r |-> !q_push)
    else $error("translate during walk produced a job");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  a_last_level_ends: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.command == fwp_pkg::CMD_READ_DATA && busy_r && last_level
    |=> !busy_r)
    else $error("walk did not end after last entry");
`endif

endmodule

// ===== src/fwp_queue.sv =====
module fwp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fwp_pkg::fwp_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output fwp_pkg::fwp_job_t pop_job
);

  fwp_pkg::fwp_job_t              mem_r [fwp_pkg::QUEUE_DEPTH];
  logic [fwp_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [fwp_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [fwp_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_pop;

  assign full    = (count_r == fwp_pkg::QCNT_W'(fwp_pkg::QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign do_pop  = pop && valid;
  assign pop_job = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_comb begin
    count_nxt = count_r;
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + fwp_pkg::QCNT_W'(1);
      2'b01:   count_nxt = count_r - fwp_pkg::QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + fwp_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + fwp_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== src/fwp_back.sv =====
module fwp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  fwp_pkg::fwp_job_t q_job,
  output logic              q_pop,
  output logic              out_valid,
  output fwp_pkg::fwp_out_t out_data,
  input  logic              out_stall
);

  logic              out_valid_r;
  fwp_pkg::fwp_out_t out_data_r, out_data_nxt;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Address adder: base plus index, final address plus direct map, or a passed-through address plus zero
  always_comb begin
    out_data_nxt.result_kind    = q_job.result_kind;
    out_data_nxt.passed_through = q_job.passed_through;
    out_data_nxt.out_address    = q_job.opnd_a + q_job.opnd_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== src/four_level_page_table_walker.sv =====
// Page table walker. Accepts one beat per cycle on the input channel:
// translate commands and memory read data. A translate with any of bits
// 63:48 set comes back unchanged with passed_through set; otherwise the
// block emits a read request for the root entry and then, for each read
// data beat, either the next level's read request or, after LEVELS
// entries, the translated address plus the direct-map offset. Every beat
// that produces a result passes first through the two-entry job queue and
// then through the output register with its 64-bit adder; a beat that
// does not fit the walk state is dropped. A full walk takes LEVELS memory
// round trips, so its length is set by the external memory latency. Input
// stalls only while the job queue is full. No clearing pass follows reset.
module four_level_page_table_walker #(
  parameter int LEVELS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  fwp_pkg::fwp_in_t               in_data,
  output logic                           in_stall,
  output logic                           out_valid,
  output fwp_pkg::fwp_out_t              out_data,
  input  logic                           out_stall,
  input  logic                           cfg_we,
  input  logic [fwp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]                    cfg_wdata
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  fwp_pkg::fwp_job_t push_job;
  fwp_pkg::fwp_job_t pop_job;

  fwp_front #(
    .LEVELS (LEVELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  fwp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  fwp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
